// ----- rtl/core/wbmrd_pkg.sv -----
// Shared widths and controller/datapath interface types for the best-match row distortion block.
`default_nettype none

package wbmrd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int SHIFT_BITS  = 11;
  localparam int WEIGHT_BITS = 8;
  localparam int NUM_CMP     = 3;

  // Shifted test sample and sample difference, both signed.
  localparam int TST_W  = ((SAMPLE_BITS > SHIFT_BITS) ? SAMPLE_BITS : SHIFT_BITS) + 1;
  localparam int DIFF_W = TST_W + 1;
  // A squared difference stays below 2^(2*(SHIFT_BITS)) for these widths.
  localparam int SQ_W   = 2 * SHIFT_BITS;
  localparam int WSQ_W  = SQ_W + WEIGHT_BITS;
  localparam int ERR_W  = 32;
  localparam int ACC_W  = 34;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SHIFT_BITS;

  typedef struct packed {
    logic load;
    logic square;
    logic weigh;
    logic compare;
    logic accum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_cand;
    logic last_pix;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/wbmrd_ctrl.sv -----
// Sequencing state machine that steps one pixel word through the datapath.
`default_nettype none

module wbmrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  wbmrd_pkg::status_t status,
  output wbmrd_pkg::cmd_t   cmd
);
  import wbmrd_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_WT   = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_ACC  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (pixel_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        state_next = ST_WT;
      end
      ST_WT: begin
        cmd.weigh  = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = status.last_cand ? ST_ACC : ST_IDLE;
      end
      ST_ACC: begin
        // A row end waits here until the output register can take the sums.
        if (!status.last_pix) begin
          cmd.accum  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.accum  = 1'b1;
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign pixel_stall = (state != ST_IDLE);

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (cmd.accum && status.out_free))
    else $error("row sums emitted without a free output register");

  a_window_continues: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && !status.last_cand) |=> (state == ST_IDLE))
    else $error("non-final candidate did not return to idle");

  a_row_end_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && status.last_pix && !status.out_free) |=> (state == ST_ACC))
    else $error("row end left the accumulate state while the output was busy");

endmodule

`default_nettype wire

// ----- rtl/core/wbmrd_datapath.sv -----
// Shift, squared-difference scoring, best-match tracking and row accumulation datapath.
`default_nettype none

module wbmrd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wbmrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbmrd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    test_y,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    test_u,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    test_v,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    ref_y,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    ref_u,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    ref_v,
  input  logic                                 last_candidate,
  input  logic                                 last_pixel,
  input  logic                                 dist_stall,
  output logic                                 dist_valid,
  output logic [wbmrd_pkg::ACC_W-1:0]          row_dist_y,
  output logic [wbmrd_pkg::ACC_W-1:0]          row_dist_u,
  output logic [wbmrd_pkg::ACC_W-1:0]          row_dist_v,
  input  wbmrd_pkg::cmd_t                      cmd,
  output wbmrd_pkg::status_t                   status
);
  import wbmrd_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_Y  = 3'd0,
    REG_SHIFT_U  = 3'd1,
    REG_SHIFT_V  = 3'd2,
    REG_WEIGHT_Y = 3'd3,
    REG_WEIGHT_U = 3'd4,
    REG_WEIGHT_V = 3'd5
  } reg_idx_t;

  logic signed [SHIFT_BITS-1:0]  shift  [NUM_CMP];
  logic        [WEIGHT_BITS-1:0] weight [NUM_CMP];

  logic        [SAMPLE_BITS-1:0] test_in [NUM_CMP];
  logic        [SAMPLE_BITS-1:0] ref_in  [NUM_CMP];

  logic signed [TST_W-1:0]       tst      [NUM_CMP];
  logic        [SAMPLE_BITS-1:0] ref_s    [NUM_CMP];
  logic        [SQ_W-1:0]        sq       [NUM_CMP];
  logic        [SQ_W-1:0]        sq_best  [NUM_CMP];
  logic        [WSQ_W-1:0]       wsq      [NUM_CMP];
  logic        [SQ_W-1:0]        sel_sq   [NUM_CMP];
  logic        [SAMPLE_BITS-1:0] best_ref [NUM_CMP];
  logic        [ACC_W-1:0]       acc      [NUM_CMP];
  logic        [ACC_W-1:0]       acc_next [NUM_CMP];
  logic        [ERR_W-1:0]       best_error;
  logic        [ERR_W-1:0]       err;
  logic                          last_cand;
  logic                          last_pix;

  logic signed [DIFF_W-1:0]      diff      [NUM_CMP];
  logic signed [DIFF_W-1:0]      diff_best [NUM_CMP];
  logic signed [2*DIFF_W-1:0]    prod      [NUM_CMP];
  logic signed [2*DIFF_W-1:0]    prod_best [NUM_CMP];
  logic        [ACC_W:0]         acc_sum   [NUM_CMP];

  assign test_in[0] = test_y;
  assign test_in[1] = test_u;
  assign test_in[2] = test_v;
  assign ref_in[0]  = ref_y;
  assign ref_in[1]  = ref_u;
  assign ref_in[2]  = ref_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift[0]  <= '0;
      shift[1]  <= '0;
      shift[2]  <= '0;
      weight[0] <= WEIGHT_BITS'(4);
      weight[1] <= WEIGHT_BITS'(1);
      weight[2] <= WEIGHT_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHIFT_Y:  shift[0]  <= $signed(cfg_data);
        REG_SHIFT_U:  shift[1]  <= $signed(cfg_data);
        REG_SHIFT_V:  shift[2]  <= $signed(cfg_data);
        REG_WEIGHT_Y: weight[0] <= cfg_data[WEIGHT_BITS-1:0];
        REG_WEIGHT_U: weight[1] <= cfg_data[WEIGHT_BITS-1:0];
        REG_WEIGHT_V: weight[2] <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CMP; c++) begin
      diff[c]      = DIFF_W'(tst[c]) - DIFF_W'($signed({1'b0, ref_s[c]}));
      diff_best[c] = DIFF_W'(tst[c]) - DIFF_W'($signed({1'b0, best_ref[c]}));
      prod[c]      = (2*DIFF_W)'(diff[c]) * (2*DIFF_W)'(diff[c]);
      prod_best[c] = (2*DIFF_W)'(diff_best[c]) * (2*DIFF_W)'(diff_best[c]);
      acc_sum[c]   = {1'b0, acc[c]} + (ACC_W + 1)'(sel_sq[c]);
      acc_next[c]  = acc_sum[c][ACC_W] ? {ACC_W{1'b1}} : acc_sum[c][ACC_W-1:0];
    end
    err = ERR_W'(wsq[0]) + ERR_W'(wsq[1]) + ERR_W'(wsq[2]);
  end

  // Pixel word capture and the two multiply stages carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < NUM_CMP; c++) begin
        tst[c]   <= TST_W'($signed({1'b0, test_in[c]})) + TST_W'(shift[c]);
        ref_s[c] <= ref_in[c];
      end
      last_cand <= last_candidate;
      last_pix  <= last_pixel;
    end
    if (cmd.square) begin
      for (int c = 0; c < NUM_CMP; c++) begin
        sq[c] <= prod[c][SQ_W-1:0];
      end
    end
    if (cmd.weigh) begin
      for (int c = 0; c < NUM_CMP; c++) begin
        wsq[c]     <= WSQ_W'(weight[c]) * WSQ_W'(sq[c]);
        sq_best[c] <= prod_best[c][SQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_error <= '1;
      for (int c = 0; c < NUM_CMP; c++) begin
        best_ref[c] <= '0;
        acc[c]      <= '0;
      end
    end else begin
      if (cmd.compare) begin
        if (err < best_error) begin
          best_error <= err;
          for (int c = 0; c < NUM_CMP; c++) begin
            best_ref[c] <= ref_s[c];
            sel_sq[c]   <= sq[c];
          end
        end else begin
          for (int c = 0; c < NUM_CMP; c++) begin
            sel_sq[c] <= sq_best[c];
          end
        end
      end
      if (cmd.accum) begin
        best_error <= '1;
        for (int c = 0; c < NUM_CMP; c++) begin
          best_ref[c] <= '0;
          acc[c]      <= cmd.emit ? '0 : acc_next[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_dist_y <= acc_next[0];
      row_dist_u <= acc_next[1];
      row_dist_v <= acc_next[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (cmd.emit) begin
      dist_valid <= 1'b1;
    end else if (!dist_stall) begin
      dist_valid <= 1'b0;
    end
  end

  assign status.last_cand = last_cand;
  assign status.last_pix  = last_pix;
  assign status.out_free  = !dist_valid || !dist_stall;

  a_emit_clears_row: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (dist_valid && acc[0] == '0 && acc[1] == '0 && acc[2] == '0))
    else $error("row end did not present sums and clear the accumulators");

  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.accum |=> (best_error == {ERR_W{1'b1}}))
    else $error("search was not restarted after the last candidate");

  a_best_never_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.compare |=> (best_error <= $past(best_error)))
    else $error("best score increased within a window");

endmodule

`default_nettype wire

// ----- rtl/core/window_best_match_row_distortion.sv -----
// Top level of the best-match row distortion block: controller plus datapath.
//
//  channel   direction  handshake                 payload
//  pixel     in         pixel_valid / pixel_stall test_y/u/v, ref_y/u/v, last_candidate,
//                                                 last_pixel
//  dist      out        dist_valid / dist_stall   row_dist_y/u/v
//  cfg       in         cfg_we                    cfg_index, cfg_data
//
// A candidate word steps through capture, square, weight and compare; the last
// candidate of a window also passes the accumulate step that updates the row sums.
// The controller stalls the pixel input until a word is through all of these steps.
// Synchronous reset restores the default weights, zero shifts and empty row sums.
// A row end waits in the accumulate step while a previous result still stalls.
`default_nettype none

module window_best_match_row_distortion (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wbmrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbmrd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    test_y,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    test_u,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    test_v,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    ref_y,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    ref_u,
  input  logic [wbmrd_pkg::SAMPLE_BITS-1:0]    ref_v,
  input  logic                                 last_candidate,
  input  logic                                 last_pixel,
  output logic                                 dist_valid,
  input  logic                                 dist_stall,
  output logic [wbmrd_pkg::ACC_W-1:0]          row_dist_y,
  output logic [wbmrd_pkg::ACC_W-1:0]          row_dist_u,
  output logic [wbmrd_pkg::ACC_W-1:0]          row_dist_v
);
  import wbmrd_pkg::*;

  cmd_t    cmd;
  status_t status;

  wbmrd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .cmd         (cmd)
  );

  wbmrd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .test_y         (test_y),
    .test_u         (test_u),
    .test_v         (test_v),
    .ref_y          (ref_y),
    .ref_u          (ref_u),
    .ref_v          (ref_v),
    .last_candidate (last_candidate),
    .last_pixel     (last_pixel),
    .dist_stall     (dist_stall),
    .dist_valid     (dist_valid),
    .row_dist_y     (row_dist_y),
    .row_dist_u     (row_dist_u),
    .row_dist_v     (row_dist_v),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

`default_nettype wire

// ----- tb/sv/window_best_match_row_distortion_tb.sv -----
// Self-checking testbench for the best-match row distortion block.
module window_best_match_row_distortion_tb;
  import wbmrd_pkg::*;

  localparam int     SMAX        = (1 << SAMPLE_BITS) - 1;
  localparam longint ROW_SUM_MAX = (longint'(1) << ACC_W) - 1;
  localparam longint NO_MATCH    = 64'hFFFF_FFFF;
  localparam int     DRAIN_GAP   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_Y, REG_SHIFT_U, REG_SHIFT_V, REG_WEIGHT_Y, REG_WEIGHT_U, REG_WEIGHT_V
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] test_y, test_u, test_v, ref_y, ref_u, ref_v;
    logic                   last_cand, last_pix;
  } pix_word_t;

  typedef struct packed {
    logic [ACC_W-1:0] y, u, v;
  } row_sums_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] ty, tu, tv, ry, ru, rv;
    logic                   lc, lp, typed;
    logic [ACC_W-1:0]       ey, eu, ev;
  } dir_row_t;

  // Directed words; the typed sums are used where they are obvious from the inputs.
  dir_row_t dir_tab [17] = '{
    '{0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0},
    '{1023, 1023, 1023, 0, 0, 0, 1, 1, 1, 1046529, 1046529, 1046529},
    '{0, 0, 0, 1023, 1023, 1023, 1, 1, 1, 1046529, 1046529, 1046529},
    '{512, 512, 512, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{512, 512, 512, 500, 512, 512, 0, 0, 0, 0, 0, 0},
    '{512, 512, 512, 512, 500, 512, 0, 0, 0, 0, 0, 0},
    '{512, 512, 512, 512, 512, 500, 1, 0, 0, 0, 0, 0},
    '{1, 2, 3, 1, 2, 3, 1, 1, 0, 0, 0, 0},
    '{10, 10, 10, 12, 10, 10, 0, 0, 0, 0, 0, 0},
    '{10, 10, 10, 10, 12, 10, 0, 0, 0, 0, 0, 0},
    '{10, 10, 10, 10, 10, 14, 0, 0, 0, 0, 0, 0},
    '{10, 10, 10, 10, 10, 12, 1, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1023, 1023, 1023, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1023, 1023, 1023, 1, 1, 0, 0, 0, 0},
    '{682, 341, 1023, 341, 682, 0, 1, 1, 0, 0, 0, 0},
    '{100, 100, 100, 90, 90, 90, 1, 0, 0, 0, 0, 0},
    '{7, 7, 7, 7, 9, 7, 1, 1, 1, 100, 104, 100}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  logic [SAMPLE_BITS-1:0] test_y = '0, test_u = '0, test_v = '0;
  logic [SAMPLE_BITS-1:0] ref_y = '0, ref_u = '0, ref_v = '0;
  logic                   last_candidate = 1'b0;
  logic                   last_pixel = 1'b0;
  logic                   dist_valid;
  logic                   dist_stall = 1'b0;
  logic [ACC_W-1:0]       row_dist_y, row_dist_u, row_dist_v;

  // Predictor state: register copies, the running window search and the row sums.
  int        color_shift [NUM_CMP];
  int        color_weight [NUM_CMP];
  longint    best_score;
  longint    best_ref [NUM_CMP];
  longint    row_sum [NUM_CMP];

  row_sums_t row_sums_q [$];
  bit        calm = 1'b0;
  int        errors = 0;
  int        words_sent = 0;
  int        rows_checked = 0;
  int        cfg_settings = 0;

  window_best_match_row_distortion u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .test_y         (test_y),
    .test_u         (test_u),
    .test_v         (test_v),
    .ref_y          (ref_y),
    .ref_u          (ref_u),
    .ref_v          (ref_v),
    .last_candidate (last_candidate),
    .last_pixel     (last_pixel),
    .dist_valid     (dist_valid),
    .dist_stall     (dist_stall),
    .row_dist_y     (row_dist_y),
    .row_dist_u     (row_dist_u),
    .row_dist_v     (row_dist_v)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Scores one candidate word, updates the search and the row sums, and says
  // whether the word closes a row.
  function automatic bit row_step(input pix_word_t w, output row_sums_t sums);
    longint tst [NUM_CMP];
    longint rs [NUM_CMP];
    longint score;
    longint d;
    longint s;
    tst[0] = longint'(w.test_y) + color_shift[0];
    tst[1] = longint'(w.test_u) + color_shift[1];
    tst[2] = longint'(w.test_v) + color_shift[2];
    rs[0]  = longint'(w.ref_y);
    rs[1]  = longint'(w.ref_u);
    rs[2]  = longint'(w.ref_v);
    sums   = '0;
    score  = 0;
    for (int c = 0; c < NUM_CMP; c++) begin
      d = tst[c] - rs[c];
      score += longint'(color_weight[c]) * d * d;
    end
    // An equal score keeps the earlier candidate.
    if (score < best_score) begin
      best_score = score;
      for (int c = 0; c < NUM_CMP; c++) best_ref[c] = rs[c];
    end
    if (!w.last_cand) return 1'b0;
    for (int c = 0; c < NUM_CMP; c++) begin
      d = tst[c] - best_ref[c];
      s = row_sum[c] + d * d;
      row_sum[c]  = (s > ROW_SUM_MAX) ? ROW_SUM_MAX : s;
      best_ref[c] = 0;
    end
    best_score = NO_MATCH;
    if (!w.last_pix) return 1'b0;
    sums.y = row_sum[0][ACC_W-1:0];
    sums.u = row_sum[1][ACC_W-1:0];
    sums.v = row_sum[2][ACC_W-1:0];
    for (int c = 0; c < NUM_CMP; c++) row_sum[c] = 0;
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SMAX[SAMPLE_BITS-1:0];
      default: return SAMPLE_BITS'($urandom_range(0, SMAX));
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] near(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > SMAX) v = SMAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic drive_word(input pix_word_t w, input bit typed = 1'b0,
                            input row_sums_t fixed = '0);
    row_sums_t predicted;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 15) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    test_y         <= w.test_y;
    test_u         <= w.test_u;
    test_v         <= w.test_v;
    ref_y          <= w.ref_y;
    ref_u          <= w.ref_u;
    ref_v          <= w.ref_v;
    last_candidate <= w.last_cand;
    last_pixel     <= w.last_pix;
    pixel_valid    <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    words_sent++;
    if (row_step(w, predicted)) row_sums_q.push_back(typed ? fixed : predicted);
  endtask

  // Holds the sender back until every row result is in, then lets words
  // that produce no result finish inside the block.
  task automatic drain_rows();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (row_sums_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e r, input int val);
    logic [CFG_DATA_W-1:0] d;
    if (r <= REG_SHIFT_V) begin
      d = val[CFG_DATA_W-1:0];
      color_shift[int'(r)] = val;
    end else begin
      // Bits above the weight field are junk and must be dropped.
      d = CFG_DATA_W'($urandom);
      d[WEIGHT_BITS-1:0] = val[WEIGHT_BITS-1:0];
      color_weight[int'(r) - NUM_CMP] = val & 255;
    end
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
  endtask

  task automatic set_config(input int sy, input int su, input int sv,
                            input int wy, input int wu, input int wv);
    drain_rows();
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_U, su);
    write_reg(REG_SHIFT_V, sv);
    write_reg(REG_WEIGHT_Y, wy);
    write_reg(REG_WEIGHT_U, wu);
    write_reg(REG_WEIGHT_V, wv);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_settings++;
  endtask

  // One row of test pixels, each with a window of candidates. Mostly well formed;
  // now and then the test pixel moves inside a window or a row-end mark shows up
  // on a candidate that is not the last one.
  task automatic send_row();
    int                     npix;
    int                     ncand;
    int                     spread;
    bit                     wide;
    logic [SAMPLE_BITS-1:0] ty, tu, tv;
    pix_word_t              w;
    npix = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    for (int p = 0; p < npix; p++) begin
      ncand  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 9);
      ty     = pick_sample();
      tu     = pick_sample();
      tv     = pick_sample();
      wide   = ($urandom_range(0, 3) == 0);
      spread = $urandom_range(0, 12);
      for (int k = 0; k < ncand; k++) begin
        if ($urandom_range(0, 39) == 0) begin
          ty = pick_sample();
          tu = pick_sample();
          tv = pick_sample();
        end
        w.test_y    = ty;
        w.test_u    = tu;
        w.test_v    = tv;
        w.ref_y     = wide ? pick_sample() : near(int'(ty) + color_shift[0], spread);
        w.ref_u     = wide ? pick_sample() : near(int'(tu) + color_shift[1], spread);
        w.ref_v     = wide ? pick_sample() : near(int'(tv) + color_shift[2], spread);
        w.last_cand = (k == ncand - 1);
        w.last_pix  = w.last_cand ? (p == npix - 1) : ($urandom_range(0, 19) == 0);
        drive_word(w);
      end
    end
  endtask

  task automatic send_rows(input int n);
    int start;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(0, 29) == 0) drain_rows();
      send_row();
    end
  endtask

  always @(negedge clk) begin
    dist_stall <= !rst && !calm && ($urandom_range(0, 99) < 15);
  end

  always @(posedge clk) begin
    row_sums_t exp_sums;
    if (!rst && dist_valid && !dist_stall) begin
      if (row_sums_q.size() == 0) begin
        report_mismatch($sformatf("row result %0d/%0d/%0d with none expected",
                                  row_dist_y, row_dist_u, row_dist_v));
      end else begin
        exp_sums = row_sums_q.pop_front();
        rows_checked++;
        if (row_dist_y !== exp_sums.y)
          report_mismatch($sformatf("row_dist_y %0d, expected %0d", row_dist_y, exp_sums.y));
        if (row_dist_u !== exp_sums.u)
          report_mismatch($sformatf("row_dist_u %0d, expected %0d", row_dist_u, exp_sums.u));
        if (row_dist_v !== exp_sums.v)
          report_mismatch($sformatf("row_dist_v %0d, expected %0d", row_dist_v, exp_sums.v));
      end
    end
  end

  initial begin
    pix_word_t w;
    row_sums_t fixed;
    for (int c = 0; c < NUM_CMP; c++) begin
      color_shift[c] = 0;
      best_ref[c]    = 0;
      row_sum[c]     = 0;
    end
    color_weight[0] = 4;
    color_weight[1] = 1;
    color_weight[2] = 1;
    best_score      = NO_MATCH;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words run with the register values left by reset.
    foreach (dir_tab[i]) begin
      w       = '{dir_tab[i].ty, dir_tab[i].tu, dir_tab[i].tv,
                  dir_tab[i].ry, dir_tab[i].ru, dir_tab[i].rv,
                  dir_tab[i].lc, dir_tab[i].lp};
      fixed   = '{dir_tab[i].ey, dir_tab[i].eu, dir_tab[i].ev};
      drive_word(w, dir_tab[i].typed, fixed);
    end

    set_config(1023, 1023, 1023, 255, 255, 255);
    send_rows(300);
    // With all weights zero every score ties, so the first candidate always wins.
    set_config(-1023, -1023, -1023, 0, 0, 0);
    send_rows(300);
    set_config(0, 0, 0, 255, 0, 1);
    send_rows(300);
    set_config(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
               int'($urandom_range(0, 40)) - 20, $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
    calm = 1'b1;
    send_rows(300);
    calm = 1'b0;
    set_config(int'($urandom_range(0, 2046)) - 1023, int'($urandom_range(0, 2046)) - 1023,
               int'($urandom_range(0, 2046)) - 1023, $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
    send_rows(300);
    set_config(0, 0, 0, 4, 1, 1);
    send_rows(300);

    // Shifts of -1023 with the default weights.
    set_config(-1023, -1023, -1023, 4, 1, 1);
    send_rows(60);

    drain_rows();
    repeat (DRAIN_GAP) @(posedge clk);
    $display("Run covered %0d pixel words under %0d register settings.",
             words_sent, cfg_settings);
    $display("%0d row results were compared field by field.", rows_checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/wbmrd_pkg.sv
rtl/core/wbmrd_ctrl.sv
rtl/core/wbmrd_datapath.sv
rtl/core/window_best_match_row_distortion.sv
tb/sv/window_best_match_row_distortion_tb.sv
